// ----- sv/smagorinsky_eddy_viscosity_stencil_defines.svh -----
// ============================================================================
// Smagorinsky eddy viscosity stencil: assertion macros
// Shared helpers for the concurrent checks of the stencil block.
// ============================================================================
`ifndef SMAGORINSKY_EDDY_VISCOSITY_STENCIL_DEFINES_SVH
`define SMAGORINSKY_EDDY_VISCOSITY_STENCIL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SEVS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SEVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sevs_pkg.sv -----
// ============================================================================
// sevs_pkg
// Shared constants and unit interface types of the eddy viscosity stencil.
// ============================================================================
`default_nettype none

package sevs_pkg;

    // Grid limits and derived widths.
    localparam int MAX_NX      = 256;
    localparam int MAX_NY      = 64;
    localparam int MAX_NZ      = 64;
    localparam int X_W         = $clog2(MAX_NX);
    localparam int Y_W         = $clog2(MAX_NY);
    localparam int Z_W         = $clog2(MAX_NZ);
    localparam int ADDR_W      = 1 + Y_W + Z_W;
    localparam int STORE_DEPTH = 2 * MAX_NY * MAX_NZ;

    // Field widths.
    localparam int VEL_W  = 32;
    localparam int WORD_W = 3 * VEL_W;
    localparam int SPC_W  = 32;
    localparam int NUT_W  = 48;

    // Gradient divider request and status.
    typedef struct packed {
        logic               start;
        logic signed [32:0] diff;
        logic [31:0]        den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               sat;
        logic signed [31:0] quot;
    } div_stat_t;

    // Square root unit request and status.
    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] root;
    } sqrt_stat_t;

    // Cube root unit request and status.
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } cbrt_req_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] root;
    } cbrt_stat_t;

endpackage

`default_nettype wire

// ----- sv/sevs_plane_ram.sv -----
// ============================================================================
// sevs_plane_ram
// Single-port plane store of cell velocities with registered read data.
// ============================================================================
`default_nettype none

module sevs_plane_ram (
    input  wire logic                        aclk,
    input  wire logic                        we,
    input  wire logic [sevs_pkg::ADDR_W-1:0] addr,
    input  wire logic [sevs_pkg::WORD_W-1:0] wdata,
    output logic      [sevs_pkg::WORD_W-1:0] rdata
);

    logic [sevs_pkg::WORD_W-1:0] mem [sevs_pkg::STORE_DEPTH];
    logic [sevs_pkg::WORD_W-1:0] rdata_reg;

    // One access per cycle: write or read, read data registered for the next cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/sevs_grad_div.sv -----
// ============================================================================
// sevs_grad_div
// Bit-serial divider forming one clipped gradient (diff * 2^23) / spacing.
// ============================================================================
`default_nettype none

module sevs_grad_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sevs_pkg::div_req_t  req,
    output sevs_pkg::div_stat_t      stat
);

    localparam logic [30:0] GRAD_MAX = '1;

    logic               busy_reg;
    logic               neg_reg;
    logic               sat_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        den_reg;
    logic [31:0]        rem_reg;
    logic [30:0]        low_reg;
    logic [30:0]        q_reg;
    logic signed [31:0] quot_reg;

    logic [32:0] mag;
    logic [31:0] den_eff;
    logic [31:0] head;
    logic [32:0] trial;
    logic        take;
    logic [30:0] q_new;

    // Operand magnitude, zero divisor counted as one LSB.
    always_comb begin
        mag     = req.diff[32] ? 33'(-req.diff) : 33'(req.diff);
        den_eff = (req.den == 32'd0) ? 32'd1 : req.den;
        head    = {7'd0, mag[32:8]};
        trial   = {rem_reg, low_reg[30]};
        take    = trial >= {1'b0, den_reg};
        q_new   = {q_reg[29:0], take};
    end

    // Overflow is found up front; otherwise one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            neg_reg <= req.diff[32];
            den_reg <= den_eff;
            if (head >= den_eff) begin
                busy_reg <= 1'b0;
                sat_reg  <= 1'b1;
                quot_reg <= req.diff[32] ? -$signed({1'b0, GRAD_MAX})
                                         : $signed({1'b0, GRAD_MAX});
            end else begin
                busy_reg <= 1'b1;
                sat_reg  <= 1'b0;
                rem_reg  <= head;
                low_reg  <= {mag[7:0], 23'd0};
                q_reg    <= '0;
                cnt_reg  <= 5'd31;
            end
        end else if (busy_reg) begin
            rem_reg <= take ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            low_reg <= {low_reg[29:0], 1'b0};
            q_reg   <= q_new;
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_reg <= 1'b0;
                quot_reg <= neg_reg ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.sat  = sat_reg;
    assign stat.quot = quot_reg;

endmodule

`default_nettype wire

// ----- sv/sevs_isqrt.sv -----
// ============================================================================
// sevs_isqrt
// Digit-by-digit integer square root of a 64-bit value, one bit per cycle.
// ============================================================================
`default_nettype none

module sevs_isqrt (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sevs_pkg::sqrt_req_t req,
    output sevs_pkg::sqrt_stat_t     stat
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] val_reg;
    logic [35:0] rem_reg;
    logic [31:0] root_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;

    always_comb begin
        rem_sh = {rem_reg[33:0], val_reg[63:62]};
        trial  = {2'b0, root_reg, 2'b01};
    end

    // Two radicand bits enter per cycle; one root bit leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            val_reg  <= req.value;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= 6'd32;
        end else if (busy_reg) begin
            val_reg <= {val_reg[61:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.root = root_reg;

endmodule

`default_nettype wire

// ----- sv/sevs_cbrt.sv -----
// ============================================================================
// sevs_cbrt
// Exact integer cube root of a*b*c, one root bit per trial round (SQ, CLO, CHI, CMP).
// ============================================================================
`default_nettype none

module sevs_cbrt (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sevs_pkg::cbrt_req_t req,
    output sevs_pkg::cbrt_stat_t     stat
);

    typedef enum logic [3:0] {
        CB_IDLE, CB_AB, CB_PLO, CB_PHI, CB_PSUM, CB_SQ, CB_CLO, CB_CHI, CB_CMP
    } cb_state_t;

    cb_state_t   state_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] c_reg;
    logic [63:0] mul_reg;
    logic [63:0] hold_reg;
    logic [63:0] acc_reg;
    logic [95:0] prod_reg;
    logic [31:0] w_reg;
    logic [4:0]  bit_reg;

    logic [31:0] trial;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [95:0] cube;

    always_comb begin
        trial = w_reg | (32'd1 << bit_reg);
        cube  = {mul_reg, 32'd0} + {32'd0, acc_reg};
    end

    // Operand select for the shared 32x32 multiplier.
    always_comb begin
        case (state_reg)
            CB_AB:   begin mul_a = a_reg;          mul_b = b_reg; end
            CB_PLO:  begin mul_a = mul_reg[31:0];  mul_b = c_reg; end
            CB_PHI:  begin mul_a = hold_reg[63:32]; mul_b = c_reg; end
            CB_SQ:   begin mul_a = trial;          mul_b = trial; end
            CB_CLO:  begin mul_a = mul_reg[31:0];  mul_b = trial; end
            CB_CHI:  begin mul_a = hold_reg[63:32]; mul_b = trial; end
            default: begin mul_a = '0;             mul_b = '0;    end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    // Build the product once, then test one trial root bit per round.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CB_IDLE;
        end else begin
            case (state_reg)
                CB_IDLE: begin
                    if (req.start) begin
                        a_reg     <= req.a;
                        b_reg     <= req.b;
                        c_reg     <= req.c;
                        state_reg <= CB_AB;
                    end
                end
                CB_AB: begin
                    state_reg <= CB_PLO;
                end
                CB_PLO: begin
                    hold_reg  <= mul_reg;
                    state_reg <= CB_PHI;
                end
                CB_PHI: begin
                    acc_reg   <= mul_reg;
                    state_reg <= CB_PSUM;
                end
                CB_PSUM: begin
                    prod_reg  <= cube;
                    w_reg     <= '0;
                    bit_reg   <= 5'd31;
                    state_reg <= CB_SQ;
                end
                CB_SQ: begin
                    state_reg <= CB_CLO;
                end
                CB_CLO: begin
                    hold_reg  <= mul_reg;
                    state_reg <= CB_CHI;
                end
                CB_CHI: begin
                    acc_reg   <= mul_reg;
                    state_reg <= CB_CMP;
                end
                CB_CMP: begin
                    if (cube <= prod_reg) begin
                        w_reg <= trial;
                    end
                    if (bit_reg == 5'd0) begin
                        state_reg <= CB_IDLE;
                    end else begin
                        bit_reg   <= bit_reg - 5'd1;
                        state_reg <= CB_SQ;
                    end
                end
                default: begin
                    state_reg <= CB_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != CB_IDLE);
    assign stat.root = w_reg;

endmodule

`default_nettype wire

// ----- sv/smagorinsky_eddy_viscosity_stencil.sv -----
// ============================================================================
// smagorinsky_eddy_viscosity_stencil
// Streams grid cells, keeps two x-planes of velocities and emits the
// Smagorinsky eddy viscosity of each interior cell.
// ============================================================================
//
//  Channel   Direction  Content
//  s_*       in         one grid cell: velocity and spacing, raster order
//  m_*       out        eddy viscosity and indices of one interior cell
//  APB       in         size_x, size_y, size_z, ghost_width, smag_constant
//
// A ghost cell goes straight to the store write. An interior cell's time is
// dominated by nine serial divisions of the gradient divider followed by
// the square root unit; a saturating gradient shortens its division. The
// cube root runs in parallel.
// Reset is synchronous; the plane store is not cleared.
// A result waits in the output register while the next cell is taken;
// the block stalls only when a second result is ready before the first
// transaction completes.
// ============================================================================
`default_nettype none
`include "smagorinsky_eddy_viscosity_stencil_defines.svh"

module smagorinsky_eddy_viscosity_stencil (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // vel_x[31:0], vel_y[63:32], vel_z[95:64],
    // spacing_x[127:96], spacing_y[159:128], spacing_z[191:160]
    input  wire logic [191:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // eddy_visc[47:0], cell_x[55:48], cell_y[61:56], cell_z[67:62], zeros
    output logic [71:0]       m_tdata,
    // saturated
    output logic [0:0]        m_tuser,
    // final_cell
    output logic              m_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_GHOST, REG_SMAG
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_DIV, ST_SQ_MUL, ST_SQ_ACC, ST_ROOT, ST_CW,
        ST_COEF, ST_P0, ST_P1, ST_NUT, ST_OUT, ST_WRITE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [8:0]  size_x_reg;
    logic [6:0]  size_y_reg;
    logic [6:0]  size_z_reg;
    logic [2:0]  ghost_reg;
    logic [15:0] smag_reg;

    // Position and plane spacing.
    logic [sevs_pkg::X_W-1:0] pos_x_reg;
    logic [sevs_pkg::Y_W-1:0] pos_y_reg;
    logic [sevs_pkg::Z_W-1:0] pos_z_reg;
    logic [31:0]              cur_dx_reg;
    logic [31:0]              ctr_dx_reg;

    // Latched cell.
    logic [sevs_pkg::WORD_W-1:0] vel_reg;
    logic [31:0]                 sy_reg;
    logic [31:0]                 sz_reg;
    logic                        lat_x0_reg;
    logic [sevs_pkg::Y_W-1:0]    lat_y_reg;
    logic [sevs_pkg::Z_W-1:0]    lat_z_reg;
    logic [7:0]                  cell_x_reg;
    logic                        final_reg;
    logic                        sat_reg;

    // Work registers.
    logic [2:0]                  rd_cnt_reg;
    logic [sevs_pkg::WORD_W-1:0] nbr_reg [5];
    logic [3:0]                  div_idx_reg;
    logic                        div_wait_reg;
    logic                        div_start_reg;
    logic                        sqrt_start_reg;
    logic                        cbrt_start_reg;
    logic signed [31:0]          grad_reg [9];
    logic [2:0]                  sq_idx_reg;
    logic                        dbl_reg;
    logic [63:0]                 sum_reg;
    logic [63:0]                 mul_reg;
    logic [63:0]                 coef_reg;
    logic [63:0]                 acc_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic [47:0]          out_nut_reg;
    logic [7:0]           out_x_reg;
    logic [5:0]           out_y_reg;
    logic [5:0]           out_z_reg;
    logic                 out_sat_reg;
    logic                 out_last_reg;
    logic [47:0]          nut_reg;

    sevs_pkg::div_req_t   div_req;
    sevs_pkg::div_stat_t  div_stat;
    sevs_pkg::sqrt_req_t  sqrt_req;
    sevs_pkg::sqrt_stat_t sqrt_stat;
    sevs_pkg::cbrt_req_t  cbrt_req;
    sevs_pkg::cbrt_stat_t cbrt_stat;

    logic                        ram_we;
    logic [sevs_pkg::ADDR_W-1:0] ram_addr;
    logic [sevs_pkg::WORD_W-1:0] ram_rdata;

    function automatic logic signed [32:0] comp(input logic [95:0] w, input int m);
        logic [31:0] v;
        v = w[m*32 +: 32];
        return {v[31], v};
    endfunction

    // Clamped sizes and the interior test of the arriving cell.
    logic [8:0] nx;
    logic [6:0] ny;
    logic [6:0] nz;
    logic [9:0] gw;
    logic [9:0] cx;
    logic [9:0] ye;
    logic [9:0] ze;
    logic       interior;
    logic       last_cell;
    logic       cfg_write;
    logic       accept;

    always_comb begin
        nx = (size_x_reg < 9'd3) ? 9'd3 :
             (size_x_reg > 9'(sevs_pkg::MAX_NX)) ? 9'(sevs_pkg::MAX_NX) : size_x_reg;
        ny = (size_y_reg < 7'd3) ? 7'd3 :
             (size_y_reg > 7'(sevs_pkg::MAX_NY)) ? 7'(sevs_pkg::MAX_NY) : size_y_reg;
        nz = (size_z_reg < 7'd3) ? 7'd3 :
             (size_z_reg > 7'(sevs_pkg::MAX_NZ)) ? 7'(sevs_pkg::MAX_NZ) : size_z_reg;
        gw = (ghost_reg < 3'd1) ? 10'd1 : (ghost_reg > 3'd4) ? 10'd4 : {7'd0, ghost_reg};
        cx = {2'b0, pos_x_reg} - 10'd1;
        ye = {4'b0, pos_y_reg};
        ze = {4'b0, pos_z_reg};
        interior = (pos_x_reg != '0) && (cx >= gw) && (cx + gw <= {1'b0, nx} - 10'd1)
                   && (ye >= gw) && (ye + gw <= {3'b0, ny} - 10'd1)
                   && (ze >= gw) && (ze + gw <= {3'b0, nz} - 10'd1);
        last_cell = (cx + gw == {1'b0, nx} - 10'd1) && (ye + gw == {3'b0, ny} - 10'd1)
                    && (ze + gw == {3'b0, nz} - 10'd1);
        cfg_write = psel && penable && pwrite && pready;
        accept    = s_tvalid && s_tready;
    end

    // Register read-back.
    always_comb begin
        case (reg_idx_t'(paddr[4:2]))
            REG_SIZE_X: prdata = {23'd0, size_x_reg};
            REG_SIZE_Y: prdata = {25'd0, size_y_reg};
            REG_SIZE_Z: prdata = {25'd0, size_z_reg};
            REG_GHOST:  prdata = {29'd0, ghost_reg};
            REG_SMAG:   prdata = {16'd0, smag_reg};
            default:    prdata = '0;
        endcase
    end

    // Gradient operands: east minus west, north minus south, top minus bottom.
    always_comb begin
        div_req.start = div_start_reg;
        case (div_idx_reg)
            4'd0:    begin div_req.diff = comp(vel_reg, 0) - comp(nbr_reg[0], 0);
                           div_req.den = ctr_dx_reg; end
            4'd1:    begin div_req.diff = comp(vel_reg, 1) - comp(nbr_reg[0], 1);
                           div_req.den = ctr_dx_reg; end
            4'd2:    begin div_req.diff = comp(vel_reg, 2) - comp(nbr_reg[0], 2);
                           div_req.den = ctr_dx_reg; end
            4'd3:    begin div_req.diff = comp(nbr_reg[1], 0) - comp(nbr_reg[2], 0);
                           div_req.den = sy_reg; end
            4'd4:    begin div_req.diff = comp(nbr_reg[1], 1) - comp(nbr_reg[2], 1);
                           div_req.den = sy_reg; end
            4'd5:    begin div_req.diff = comp(nbr_reg[1], 2) - comp(nbr_reg[2], 2);
                           div_req.den = sy_reg; end
            4'd6:    begin div_req.diff = comp(nbr_reg[3], 0) - comp(nbr_reg[4], 0);
                           div_req.den = sz_reg; end
            4'd7:    begin div_req.diff = comp(nbr_reg[3], 1) - comp(nbr_reg[4], 1);
                           div_req.den = sz_reg; end
            default: begin div_req.diff = comp(nbr_reg[3], 2) - comp(nbr_reg[4], 2);
                           div_req.den = sz_reg; end
        endcase
    end

    // Strain terms: doubled diagonal squares, then the three shear sums.
    logic signed [32:0] sq_sum;
    logic               sq_dbl;
    logic [31:0]        sq_mag;

    always_comb begin
        case (sq_idx_reg)
            3'd0:    begin sq_sum = 33'(grad_reg[0]); sq_dbl = 1'b1; end
            3'd1:    begin sq_sum = 33'(grad_reg[4]); sq_dbl = 1'b1; end
            3'd2:    begin sq_sum = 33'(grad_reg[8]); sq_dbl = 1'b1; end
            3'd3:    begin sq_sum = 33'(grad_reg[3]) + 33'(grad_reg[1]); sq_dbl = 1'b0; end
            3'd4:    begin sq_sum = 33'(grad_reg[7]) + 33'(grad_reg[5]); sq_dbl = 1'b0; end
            default: begin sq_sum = 33'(grad_reg[6]) + 33'(grad_reg[2]); sq_dbl = 1'b0; end
        endcase
        sq_mag = sq_sum[32] ? 32'(-sq_sum) : sq_sum[31:0];
    end

    // Shared multiplier operand select.
    logic [31:0] mul_a;
    logic [31:0] mul_b;

    always_comb begin
        case (state_reg)
            ST_SQ_MUL: begin mul_a = sq_mag;           mul_b = sq_mag;           end
            ST_CW:     begin mul_a = cbrt_stat.root;   mul_b = {16'd0, smag_reg}; end
            ST_COEF:   begin mul_a = mul_reg[47:16];   mul_b = mul_reg[47:16];   end
            ST_P0:     begin mul_a = mul_reg[31:0];    mul_b = sqrt_stat.root;   end
            ST_P1:     begin mul_a = coef_reg[63:32];  mul_b = sqrt_stat.root;   end
            default:   begin mul_a = '0;               mul_b = '0;               end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    // Sum, product and store address helpers.
    logic [63:0] sq_term;
    logic [64:0] sum_ext;
    logic [95:0] nut_prod;

    always_comb begin
        sq_term  = dbl_reg ? {mul_reg[62:0], 1'b0} : mul_reg;
        sum_ext  = {1'b0, sum_reg} + {1'b0, sq_term};
        nut_prod = {mul_reg, 32'd0} + {32'd0, acc_reg};
    end

    always_comb begin
        ram_we   = (state_reg == ST_WRITE);
        ram_addr = {lat_x0_reg, lat_y_reg, lat_z_reg};
        if (state_reg == ST_READ) begin
            case (rd_cnt_reg)
                3'd1:    ram_addr = {~lat_x0_reg, lat_y_reg + 6'd1, lat_z_reg};
                3'd2:    ram_addr = {~lat_x0_reg, lat_y_reg - 6'd1, lat_z_reg};
                3'd3:    ram_addr = {~lat_x0_reg, lat_y_reg, lat_z_reg + 6'd1};
                3'd4:    ram_addr = {~lat_x0_reg, lat_y_reg, lat_z_reg - 6'd1};
                default: ram_addr = {lat_x0_reg, lat_y_reg, lat_z_reg};
            endcase
        end
    end

    assign sqrt_req.start = sqrt_start_reg;
    assign sqrt_req.value = sum_reg;
    assign cbrt_req.start = cbrt_start_reg;
    assign cbrt_req.a     = ctr_dx_reg;
    assign cbrt_req.b     = sy_reg;
    assign cbrt_req.c     = sz_reg;

    // Sequencer, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            size_x_reg     <= 9'd256;
            size_y_reg     <= 7'd64;
            size_z_reg     <= 7'd64;
            ghost_reg      <= 3'd1;
            smag_reg       <= 16'd6554;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            pos_z_reg      <= '0;
            cur_dx_reg     <= '0;
            ctr_dx_reg     <= '0;
            div_wait_reg   <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            cbrt_start_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_SIZE_X: size_x_reg <= pwdata[8:0];
                    REG_SIZE_Y: size_y_reg <= pwdata[6:0];
                    REG_SIZE_Z: size_z_reg <= pwdata[6:0];
                    REG_GHOST:  ghost_reg  <= pwdata[2:0];
                    REG_SMAG:   smag_reg   <= pwdata[15:0];
                    default:    ;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            cbrt_start_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        vel_reg    <= s_tdata[95:0];
                        sy_reg     <= s_tdata[159:128];
                        sz_reg     <= s_tdata[191:160];
                        lat_x0_reg <= pos_x_reg[0];
                        lat_y_reg  <= pos_y_reg;
                        lat_z_reg  <= pos_z_reg;
                        cell_x_reg <= cx[7:0];
                        final_reg  <= last_cell;
                        sat_reg    <= 1'b0;
                        rd_cnt_reg <= '0;
                        if (pos_y_reg == '0 && pos_z_reg == '0) begin
                            ctr_dx_reg <= cur_dx_reg;
                            cur_dx_reg <= s_tdata[127:96];
                        end
                        // Advance the raster position.
                        if ({1'b0, pos_z_reg} + 7'd1 >= nz) begin
                            pos_z_reg <= '0;
                            if ({1'b0, pos_y_reg} + 7'd1 >= ny) begin
                                pos_y_reg <= '0;
                                pos_x_reg <= ({1'b0, pos_x_reg} + 9'd1 >= nx) ? '0
                                             : pos_x_reg + 8'd1;
                            end else begin
                                pos_y_reg <= pos_y_reg + 6'd1;
                            end
                        end else begin
                            pos_z_reg <= pos_z_reg + 6'd1;
                        end
                        if (interior) begin
                            cbrt_start_reg <= 1'b1;
                            state_reg      <= ST_READ;
                        end else begin
                            state_reg <= ST_WRITE;
                        end
                    end
                end
                ST_READ: begin
                    // Five neighbor reads; the data of each shifts in during the next cycle.
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg != 3'd0) begin
                        for (int i = 0; i < 4; i++) begin
                            nbr_reg[i] <= nbr_reg[i+1];
                        end
                        nbr_reg[4] <= ram_rdata;
                    end
                    if (rd_cnt_reg == 3'd5) begin
                        div_idx_reg  <= '0;
                        div_wait_reg <= 1'b0;
                        state_reg    <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!div_wait_reg) begin
                        div_start_reg <= 1'b1;
                        div_wait_reg  <= 1'b1;
                    end else if (!div_start_reg && !div_stat.busy) begin
                        for (int i = 0; i < 8; i++) begin
                            grad_reg[i] <= grad_reg[i+1];
                        end
                        grad_reg[8]  <= div_stat.quot;
                        sat_reg      <= sat_reg | div_stat.sat;
                        div_wait_reg <= 1'b0;
                        div_idx_reg  <= div_idx_reg + 4'd1;
                        if (div_idx_reg == 4'd8) begin
                            sq_idx_reg <= '0;
                            sum_reg    <= '0;
                            state_reg  <= ST_SQ_MUL;
                        end
                    end
                end
                ST_SQ_MUL: begin
                    dbl_reg   <= sq_dbl;
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC: begin
                    if (sum_ext[64]) begin
                        sum_reg <= '1;
                        sat_reg <= 1'b1;
                    end else begin
                        sum_reg <= sum_ext[63:0];
                    end
                    sq_idx_reg <= sq_idx_reg + 3'd1;
                    if (sq_idx_reg == 3'd5) begin
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT;
                    end else begin
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_ROOT: begin
                    if (!sqrt_start_reg && !sqrt_stat.busy && !cbrt_start_reg
                        && !cbrt_stat.busy) begin
                        state_reg <= ST_CW;
                    end
                end
                ST_CW: begin
                    state_reg <= ST_COEF;
                end
                ST_COEF: begin
                    state_reg <= ST_P0;
                end
                ST_P0: begin
                    coef_reg  <= mul_reg;
                    state_reg <= ST_P1;
                end
                ST_P1: begin
                    acc_reg   <= mul_reg;
                    state_reg <= ST_NUT;
                end
                ST_NUT: begin
                    if (nut_prod[95:88] != '0) begin
                        nut_reg <= '1;
                        sat_reg <= 1'b1;
                    end else begin
                        nut_reg <= nut_prod[87:40];
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        out_nut_reg  <= nut_reg;
                        out_x_reg    <= cell_x_reg;
                        out_y_reg    <= lat_y_reg;
                        out_z_reg    <= lat_z_reg;
                        out_sat_reg  <= sat_reg;
                        out_last_reg <= final_reg;
                        state_reg    <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Arithmetic units and the plane store.
    sevs_grad_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat)
    );

    sevs_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .stat    (sqrt_stat)
    );

    sevs_cbrt u_cbrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cbrt_req),
        .stat    (cbrt_stat)
    );

    sevs_plane_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (vel_reg),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_z_reg, out_y_reg, out_x_reg, out_nut_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

    // Checks on the sequencer.
    `SEVS_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != ST_IDLE, "accepted transaction did not start work")
    `SEVS_ASSERT_NOW(a_valid_from_out, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == ST_OUT), "result raised outside of output step")
    `SEVS_ASSERT_NOW(a_div_not_busy, aclk, aresetn, div_start_reg, !div_stat.busy, "divider started while busy")
    `SEVS_ASSERT_NOW(a_roots_ready, aclk, aresetn, state_reg == ST_CW, !cbrt_stat.busy && !sqrt_stat.busy, "root units still busy at final product")

endmodule

`default_nettype wire
